// ----- hw/rtl/scc_pkg.sv -----
// shared types and the byte-wide crc-8 update for the scratchpad check block
// no dependencies
package scc_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned PosW       = 4;
  localparam logic [7:0]  CrcPoly    = 8'h8C;
  localparam logic [7:0]  ByteZero   = 8'h00;
  localparam logic [7:0]  ByteOnes   = 8'hFF;
  localparam logic [3:0]  PosTempLo  = 4'd0;
  localparam logic [3:0]  PosTempHi  = 4'd1;
  localparam logic [3:0]  PosCrcByte = 4'd8;

  // per-transaction frame status handed from the frame tracker to the top
  typedef struct packed {
    logic             last;
    logic             crc_match;
    logic             plausible;
    logic [WordW-1:0] raw_word;
  } frame_stat_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    logic       mix;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < 8; k++) begin
      mix  = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

// ----- hw/rtl/scc_frame.sv -----
// frame tracker: byte position, running crc, all-zero / all-ones flags, temp bytes
// depends on scc_pkg
module scc_frame (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [scc_pkg::ByteW-1:0] byte_i,
  output scc_pkg::frame_stat_t      stat_o
);
  import scc_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       crc_q, crc_d;
  logic             all_zero_q, all_zero_d;
  logic             all_ones_q, all_ones_d;
  logic [ByteW-1:0] temp_lo_q, temp_lo_d;
  logic [ByteW-1:0] temp_hi_q, temp_hi_d;

  logic is_last;
  logic zero_now;
  logic ones_now;

  assign is_last  = (pos_q >= PosCrcByte);
  assign zero_now = all_zero_q && (byte_i == ByteZero);
  assign ones_now = all_ones_q && (byte_i == ByteOnes);

  always_comb begin
    stat_o.last      = is_last;
    stat_o.crc_match = (crc_q == byte_i);
    stat_o.plausible = !zero_now && !ones_now;
    stat_o.raw_word  = {temp_hi_q, temp_lo_q};
  end

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    all_zero_d = all_zero_q;
    all_ones_d = all_ones_q;
    temp_lo_d  = temp_lo_q;
    temp_hi_d  = temp_hi_q;
    if (accept_i) begin
      if (is_last) begin
        // frame done, back to the reset state
        pos_d      = '0;
        crc_d      = '0;
        all_zero_d = 1'b1;
        all_ones_d = 1'b1;
        temp_lo_d  = '0;
        temp_hi_d  = '0;
      end else begin
        pos_d      = pos_q + 1'b1;
        crc_d      = crc8_byte(crc_q, byte_i);
        all_zero_d = zero_now;
        all_ones_d = ones_now;
        if (pos_q == PosTempLo) begin
          temp_lo_d = byte_i;
        end
        if (pos_q == PosTempHi) begin
          temp_hi_d = byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      crc_q      <= '0;
      all_zero_q <= 1'b1;
      all_ones_q <= 1'b1;
      temp_lo_q  <= '0;
      temp_hi_q  <= '0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      all_zero_q <= all_zero_d;
      all_ones_q <= all_ones_d;
      temp_lo_q  <= temp_lo_d;
      temp_hi_q  <= temp_hi_d;
    end
  end

endmodule

// ----- hw/rtl/scc_temp.sv -----
// raw temperature word to hundredths of a degree: x*100/16, truncated toward zero
// depends on scc_pkg
module scc_temp (
  input  logic        [scc_pkg::WordW-1:0] raw_word_i,
  output logic signed [scc_pkg::WordW-1:0] centi_o
);
  import scc_pkg::*;

  localparam int unsigned ProdW = WordW + 7;

  logic signed [ProdW-1:0] raw_ext;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] adj;
  logic signed [ProdW-1:0] quot;

  assign raw_ext = ProdW'(signed'(raw_word_i));
  // times 100 as 64 + 32 + 4
  assign prod    = (raw_ext <<< 6) + (raw_ext <<< 5) + (raw_ext <<< 2);
  // bias negatives so the shift rounds toward zero
  assign adj     = prod + (prod[ProdW-1] ? ProdW'(15) : ProdW'(0));
  assign quot    = adj >>> 4;
  assign centi_o = quot[WordW-1:0];

endmodule

// ----- hw/rtl/sensor_scratchpad_check_and_convert_top.sv -----
// scratchpad check and convert: one byte per transaction, one result per nine bytes
// result: registered into the output register as the ninth byte is accepted
// throughput: one byte every cycle; input stalls only while a result waits stalled
// reset: rst_ni asynchronous active low, frame state cleared, output empty
// depends on scc_pkg, scc_frame, scc_temp
module sensor_scratchpad_check_and_convert_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // byte channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic        [scc_pkg::ByteW-1:0] scratch_byte_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             frame_ok_o,
  output logic                             crc_match_o,
  output logic                             plausible_o,
  output logic signed [scc_pkg::WordW-1:0] temp_hundredths_o
);
  import scc_pkg::*;

  frame_stat_t              stat;
  logic                     in_accept;
  logic                     out_load;
  logic signed [WordW-1:0]  centi;
  logic                     ok;

  // output register state
  logic                     out_valid_q, out_valid_d;
  logic                     frame_ok_q, frame_ok_d;
  logic                     crc_match_q, crc_match_d;
  logic                     plausible_q, plausible_d;
  logic signed [WordW-1:0]  temp_q, temp_d;

  // the output register can take a new result when empty or being drained
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  scc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (scratch_byte_i),
    .stat_o   (stat)
  );

  scc_temp u_temp (
    .raw_word_i (stat.raw_word),
    .centi_o    (centi)
  );

  // frame is rejected only when crc fails and the frame is all zero or all ones
  assign ok = stat.crc_match || stat.plausible;

  always_comb begin
    out_valid_d = out_valid_q;
    frame_ok_d  = frame_ok_q;
    crc_match_d = crc_match_q;
    plausible_d = plausible_q;
    temp_d      = temp_q;
    if (out_load) begin
      out_valid_d = in_accept && stat.last;
      frame_ok_d  = ok;
      crc_match_d = stat.crc_match;
      plausible_d = stat.plausible;
      // rejected frames report zero temperature
      temp_d      = ok ? centi : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    frame_ok_q  <= frame_ok_d;
    crc_match_q <= crc_match_d;
    plausible_q <= plausible_d;
    temp_q      <= temp_d;
  end

  assign out_valid_o       = out_valid_q;
  assign frame_ok_o        = frame_ok_q;
  assign crc_match_o       = crc_match_q;
  assign plausible_o       = plausible_q;
  assign temp_hundredths_o = temp_q;

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for sensor_scratchpad_check_and_convert_top
// predicts crc, plausibility and scaled temperature per nine-byte frame
// depends on scc_pkg and the rtl of the scratchpad check block
`timescale 1ns / 100ps

module tb;

  import scc_pkg::*;

  localparam int unsigned RandomBytes = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned IdlePct     = 32;
  localparam int unsigned QuietFrom   = 700;   // both sides stop idling here
  localparam int unsigned QuietTo     = 1000;
  localparam int unsigned HoldFrom    = 200;   // receiver starts its long hold-off
  localparam int unsigned HoldLen     = 60;
  localparam int unsigned FrameBytes  = 9;

  // one byte waiting to be sent, optionally only after all results are back
  typedef struct {
    logic [ByteW-1:0] value;
    bit               wait_drain;
  } pending_byte_t;

  // fields of one frame verdict
  typedef struct packed {
    logic                    frame_ok;
    logic                    crc_match;
    logic                    plausible;
    logic signed [WordW-1:0] temp_hundredths;
  } frame_verdict_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic [ByteW-1:0]        scratch_byte_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic                    frame_ok_o;
  logic                    crc_match_o;
  logic                    plausible_o;
  logic signed [WordW-1:0] temp_hundredths_o;

  pending_byte_t  byte_q[$];
  frame_verdict_t verdict_q[$];

  int unsigned send_idx     = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rx_cycles    = 0;
  int unsigned fail_cnt     = 0;
  int unsigned n_rejected   = 0;
  int unsigned n_crc_bad    = 0;

  // predictor's copy of the frame state
  logic [PosW-1:0]  pred_pos;
  logic [ByteW-1:0] pred_crc;
  logic             pred_all_zero;
  logic             pred_all_ones;
  logic [ByteW-1:0] pred_lo;
  logic [ByteW-1:0] pred_hi;

  // driver scratch variables
  int unsigned next_idx;
  bit          tx_idle;
  bit          may_send;

  // monitor scratch variables
  bit             frame_done;
  frame_verdict_t new_verdict;
  frame_verdict_t want;

  sensor_scratchpad_check_and_convert_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .scratch_byte_i   (scratch_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_ok_o       (frame_ok_o),
    .crc_match_o      (crc_match_o),
    .plausible_o      (plausible_o),
    .temp_hundredths_o(temp_hundredths_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // reflected crc-8 over one byte: each data bit, lsb first, against the crc lsb
  function automatic logic [ByteW-1:0] crc8_reflect(input logic [ByteW-1:0] crc,
                                                    input logic [ByteW-1:0] data);
    logic [ByteW-1:0] acc;
    acc = crc;
    for (int i = 0; i < ByteW; i++) begin
      if (acc[0] ^ data[i]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic clear_frame_state();
    pred_pos      = '0;
    pred_crc      = '0;
    pred_all_zero = 1'b1;
    pred_all_ones = 1'b1;
    pred_lo       = '0;
    pred_hi       = '0;
  endtask

  // take one accepted byte; after the crc byte hand back the frame verdict
  task automatic absorb_scratch_byte(input logic [ByteW-1:0] b, output bit done,
                                     output frame_verdict_t v);
    int raw;
    int centi;
    done = 1'b0;
    v    = '0;
    if (b != ByteZero) pred_all_zero = 1'b0;
    if (b != ByteOnes) pred_all_ones = 1'b0;
    if (pred_pos < PosCrcByte) begin
      pred_crc = crc8_reflect(pred_crc, b);
      if (pred_pos == PosTempLo) begin
        pred_lo = b;
      end else if (pred_pos == PosTempHi) begin
        pred_hi = b;
      end
      pred_pos = pred_pos + 1'b1;
    end else begin
      // crc byte closes the frame
      raw         = $signed({pred_hi, pred_lo});
      centi       = (raw * 100) / 16;   // truncates toward zero
      v.crc_match = (pred_crc == b);
      v.plausible = !pred_all_zero && !pred_all_ones;
      v.frame_ok  = v.crc_match || v.plausible;
      // a rejected frame reports zero temperature
      v.temp_hundredths = v.frame_ok ? centi[WordW-1:0] : '0;
      done = 1'b1;
      clear_frame_state();
    end
  endtask

  // queue a nine-byte frame; the first byte may wait for all results to drain
  task automatic push_frame(input logic [ByteW-1:0] fb[FrameBytes], input bit wait_drain);
    pending_byte_t p;
    for (int i = 0; i < FrameBytes; i++) begin
      p.value      = fb[i];
      p.wait_drain = (i == 0) && wait_drain;
      byte_q.push_back(p);
    end
  endtask

  function automatic logic [ByteW-1:0] frame_crc(input logic [ByteW-1:0] fb[FrameBytes]);
    logic [ByteW-1:0] c;
    c = '0;
    for (int i = 0; i < FrameBytes - 1; i++) begin
      c = crc8_reflect(c, fb[i]);
    end
    return c;
  endfunction

  // driver: offers queued bytes, holds a stalled transaction, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      scratch_byte_i <= '0;
      send_idx       <= 0;
    end else begin
      next_idx = send_idx;
      if (in_valid_i && !in_stall_o) begin
        next_idx = send_idx + 1;
      end
      send_idx <= next_idx;
      tx_idle  = (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) ? 1'b0 :
                 ($urandom_range(0, 99) < IdlePct);
      may_send = (next_idx < byte_q.size());
      // a draining pause waits for the results of every earlier frame
      if (may_send && byte_q[next_idx].wait_drain) begin
        may_send = (results_seen == next_idx / FrameBytes);
      end
      if (in_valid_i && in_stall_o) begin
        // stalled transaction stays on the bus unchanged
      end else if (may_send && !tx_idle) begin
        in_valid_i     <= 1'b1;
        scratch_byte_i <= byte_q[next_idx].value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_cycles   <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles >= HoldFrom && rx_cycles < HoldFrom + HoldLen) begin
        out_stall_i <= 1'b1;
      end else if (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // monitor: predict on accepted bytes, check accepted results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame_state();
      results_seen <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_scratch_byte(scratch_byte_i, frame_done, new_verdict);
        if (frame_done) verdict_q.push_back(new_verdict);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("result transaction with no frame outstanding");
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (!want.frame_ok) n_rejected++;
          if (!want.crc_match) n_crc_bad++;
          if (frame_ok_o !== want.frame_ok) begin
            $error("frame_ok: expected %0b, got %0b", want.frame_ok, frame_ok_o);
            fail_cnt++;
          end
          if (crc_match_o !== want.crc_match) begin
            $error("crc_match: expected %0b, got %0b", want.crc_match, crc_match_o);
            fail_cnt++;
          end
          if (plausible_o !== want.plausible) begin
            $error("plausible: expected %0b, got %0b", want.plausible, plausible_o);
            fail_cnt++;
          end
          if (temp_hundredths_o !== want.temp_hundredths) begin
            $error("temp_hundredths: expected %0d, got %0d",
                   want.temp_hundredths, temp_hundredths_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0]  fb[FrameBytes];
    logic [WordW-1:0]  word;
    int unsigned       kind;
    int unsigned       n_frames;
    int unsigned       spot;
    logic [WordW-1:0]  corner_words[6];

    corner_words = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFC90};

    // directed: all-zero frame (crc matches), all-0xff frame (rejected),
    // largest raw word with good crc (scaled value wraps)
    foreach (fb[i]) fb[i] = ByteZero;
    push_frame(fb, 1'b0);
    foreach (fb[i]) fb[i] = ByteOnes;
    push_frame(fb, 1'b0);
    fb[0] = 8'hFF;
    fb[1] = 8'h7F;
    for (int i = 2; i < FrameBytes - 1; i++) fb[i] = 8'h00;
    fb[8] = frame_crc(fb);
    push_frame(fb, 1'b0);

    n_frames = 0;
    while (byte_q.size() < 3 * FrameBytes + RandomBytes) begin
      kind = $urandom_range(0, 99);
      word = ($urandom_range(0, 4) == 0) ? corner_words[$urandom_range(0, 5)]
                                          : WordW'($urandom_range(0, 16'hFFFF));
      fb[0] = word[7:0];
      fb[1] = word[15:8];
      for (int i = 2; i < FrameBytes - 1; i++) fb[i] = ByteW'($urandom_range(0, 255));
      fb[8] = frame_crc(fb);
      if (kind < 60) begin
        // well-formed frame
      end else if (kind < 75) begin
        // corrupted crc byte
        fb[8] = fb[8] ^ ByteW'($urandom_range(1, 255));
      end else if (kind < 83) begin
        foreach (fb[i]) fb[i] = ByteOnes;
      end else if (kind < 88) begin
        foreach (fb[i]) fb[i] = ByteZero;
      end else begin
        // all 0xff or all zero but one byte
        spot = $urandom_range(0, FrameBytes - 2);
        foreach (fb[i]) fb[i] = (kind < 94) ? ByteOnes : ByteZero;
        fb[spot] = ByteW'($urandom_range(0, 255));
        fb[8] = $urandom_range(0, 1) ? frame_crc(fb) : fb[8];
      end
      push_frame(fb, (n_frames % 25) == 12);
      n_frames++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do begin
      @(posedge clk_i);
    end while (!(send_idx == byte_q.size() && verdict_q.size() == 0));
    repeat (DrainCycles) @(posedge clk_i);

    if (verdict_q.size() != 0) begin
      $error("%0d frame results never arrived", verdict_q.size());
      fail_cnt++;
    end

    $display("%0d scratchpad bytes in %0d frames checked, %0d rejected, %0d crc mismatches",
             byte_q.size(), results_seen, n_rejected, n_crc_bad);
    $display("random stalls on both sides, one long output hold-off, %0d cycles", cycle_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/scc_pkg.sv
hw/rtl/scc_frame.sv
hw/rtl/scc_temp.sv
hw/rtl/sensor_scratchpad_check_and_convert_top.sv
sim/tb.sv
